### rtl/multi_stack_engine_macros.svh
// Assertion macros for the stack engine modules; used by mse_back.
// No dependencies; included by files that carry assertions.
`ifndef MULTI_STACK_ENGINE_MACROS_SVH
`define MULTI_STACK_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSE_ASSERT(label, clk, rst_n, prop, msg)
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mse_pkg.sv
// Shared types and constants for the multi-stack engine.
// No dependencies.
package mse_pkg;
	localparam int DefStackCount = 26;
	localparam int DefStackDepth = 64;
	localparam int DefValueWidth = 32;
	localparam int InWidth = 32;
	localparam int OpWidth = 3;
	localparam int IdxWidth = 5;
	localparam int CntWidth = 7;
	localparam int StWidth = 2;

	typedef enum logic [OpWidth-1:0] {
		OP_SELECT = 3'd0, OP_PUSH = 3'd1, OP_POP = 3'd2, OP_PEEK = 3'd3,
		OP_SWAP = 3'd4, OP_CLEAR = 3'd5, OP_COPY = 3'd6, OP_NOP = 3'd7
	} op_t;

	typedef enum logic [StWidth-1:0] {
		ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_NOSTACK = 2'd3
	} status_t;

	// command handed from the front end to the back end
	typedef struct packed {
		op_t                  op;
		logic [InWidth-1:0]   value;
		logic [IdxWidth-1:0]  index;
		logic [CntWidth-1:0]  count;
		logic                 nostack; // no valid selection or copy target: answer NOSTACK
	} cmd_t;

	typedef enum logic [2:0] {
		BE_IDLE, BE_RD, BE_SWAP_RD2, BE_SWAP_WR, BE_PEEK, BE_COPY, BE_OUT
	} be_state_t;
endpackage

### rtl/multi_stack_engine.sv
// Top level of the multi-stack engine: front end, command queue, back end.
// Depends on mse_pkg, mse_front and mse_back.
//
// Usage: input transactions (opcode, push_value, stack_index, peek_count)
// arrive on in_valid/in_stall; results (read_value, status, last_result)
// leave on out_valid/out_stall. Every transaction yields one result, except
// peek, which yields one per shown entry, last_result marking the final one.
// The front end holds a two-entry command queue, so input is taken while the
// back end works. The back end handles one command at a time: push, clear,
// select and no-op finish in the decode state, while pop, swap, peek and
// copy can take further states, set by the single read and single write
// port of the content memory. Results are registered.
// Reset clears all heights and the selection; content memory is not
// cleared. When the receiver stalls, the result register holds and the back
// end waits; the queue then fills and in_stall rises.
module multi_stack_engine
	import mse_pkg::*;
#(
	parameter int STACK_COUNT = mse_pkg::DefStackCount,
	parameter int STACK_DEPTH = mse_pkg::DefStackDepth,
	parameter int VALUE_WIDTH = mse_pkg::DefValueWidth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mse_pkg::OpWidth-1:0]   opcode,
	input  logic [mse_pkg::InWidth-1:0]   push_value,
	input  logic [mse_pkg::IdxWidth-1:0]  stack_index,
	input  logic [mse_pkg::CntWidth-1:0]  peek_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mse_pkg::InWidth-1:0]   read_value,
	output logic [mse_pkg::StWidth-1:0]   status,
	output logic                          last_result
);
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	mse_front #(.STACK_COUNT(STACK_COUNT)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .push_value,
		.stack_index, .peek_count, .cmd_valid, .cmd_take, .cmd
	);

	mse_back #(
		.STACK_COUNT(STACK_COUNT), .STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd, .out_valid, .out_stall,
		.read_value, .status, .last_result
	);
endmodule

### rtl/mse_front.sv
// Front end: accepts transactions, tracks the selection and queues every
// command, select and no-op included, for the back end. Uses mse_pkg.
module mse_front #(
	parameter int STACK_COUNT = 26
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mse_pkg::OpWidth-1:0]   opcode,
	input  logic [mse_pkg::InWidth-1:0]   push_value,
	input  logic [mse_pkg::IdxWidth-1:0]  stack_index,
	input  logic [mse_pkg::CntWidth-1:0]  peek_count,
	output logic                          cmd_valid,
	input  logic                          cmd_take,
	output mse_pkg::cmd_t                 cmd
);
	import mse_pkg::*;
	localparam int QDepth = 2;

	cmd_t q_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       sel_valid_q;
	logic [IdxWidth-1:0] sel_q;
	logic       acc;
	cmd_t       c;

	assign in_stall = (cnt_q == 2'(QDepth));
	assign acc = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_comb begin
		c.op = op_t'(opcode);
		c.value = push_value;
		c.index = stack_index;
		c.count = peek_count;
		c.nostack = !sel_valid_q;
		if (op_t'(opcode) == OP_SELECT)
			c.nostack = !(32'(stack_index) < STACK_COUNT);
		else if (op_t'(opcode) == OP_COPY && !(32'(stack_index) < STACK_COUNT))
			c.nostack = 1'b1;
		else if (op_t'(opcode) == OP_NOP)
			c.nostack = 1'b0;
		else
			c.index = (op_t'(opcode) == OP_COPY) ? stack_index : sel_q;
		// all but select and no-op carry the selected stack; copy target rides in count
		if (op_t'(opcode) == OP_COPY)
			c.count = {{(CntWidth-IdxWidth){1'b0}}, stack_index};
		if (op_t'(opcode) != OP_SELECT && op_t'(opcode) != OP_NOP)
			c.index = sel_q;
	end

	always_ff @(posedge clk) begin
		if (acc) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
			sel_valid_q <= 1'b0;
			sel_q <= '0;
		end else begin
			if (acc) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take);
			if (acc && op_t'(opcode) == OP_SELECT) begin
				if (32'(stack_index) < STACK_COUNT) begin
					sel_valid_q <= 1'b1;
					sel_q <= stack_index;
				end else begin
					sel_valid_q <= 1'b0;
				end
			end
		end
	end
endmodule

### rtl/mse_back.sv
// Back end: executes stack commands against the content memory and the
// height registers, and drives the result channel. Uses mse_pkg.
`include "multi_stack_engine_macros.svh"
module mse_back #(
	parameter int STACK_COUNT = 26,
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_take,
	input  mse_pkg::cmd_t                cmd,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mse_pkg::InWidth-1:0]  read_value,
	output logic [mse_pkg::StWidth-1:0]  status,
	output logic                         last_result
);
	import mse_pkg::*;
	localparam int SW = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
	localparam int DW = $clog2(STACK_DEPTH);
	localparam int HW = $clog2(STACK_DEPTH + 1);
	localparam int AW = SW + DW;

	logic [VALUE_WIDTH-1:0] mem [STACK_COUNT * STACK_DEPTH];
	logic [HW-1:0] height_q [STACK_COUNT];

	be_state_t state_q, state_d;
	cmd_t      cmd_q;
	logic [HW-1:0] h_q, i_q, n_q;
	logic [VALUE_WIDTH-1:0] rd_q, tmp_q;
	logic      rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic      rdv_q; // read data valid for copy/peek pipeline
	logic [HW-1:0] wi_q;
	logic      swap_wr2_q;

	logic [InWidth-1:0]  ov_q;
	logic [StWidth-1:0]  os_q;
	logic                ol_q, ovld_q;
	logic                emit;
	logic [InWidth-1:0]  ev;
	status_t             es;
	logic                el;
	logic [SW-1:0] s, tgt;
	logic [HW-1:0] hs;
	logic [HW-1:0] h_set;
	logic          h_we;
	logic [SW-1:0] h_idx;
	logic          free;

	assign s = cmd_q.index[SW-1:0];
	assign tgt = cmd_q.count[SW-1:0];
	assign hs = height_q[cmd.index[SW-1:0]];
	assign free = !ovld_q || !out_stall;

	function automatic logic [AW-1:0] addr(input logic [SW-1:0] st, input logic [HW-1:0] e);
		addr = AW'(st) * AW'(STACK_DEPTH) + AW'(e);
	endfunction

	function automatic logic [InWidth-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		to_out = w[InWidth-1:0];
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] to_val(input logic [InWidth-1:0] v);
		logic [63:0] w;
		w = {{(64-InWidth){v[InWidth-1]}}, v};
		to_val = w[VALUE_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		cmd_take = 1'b0;
		rd_en = 1'b0; rd_addr = '0;
		wr_en = 1'b0; wr_addr = '0; wr_data = '0;
		emit = 1'b0; ev = '0; es = ST_OK; el = 1'b1;
		h_we = 1'b0; h_idx = s; h_set = '0;
		unique case (state_q)
			BE_IDLE: begin
				// second swap write lands after output is committed
				if (swap_wr2_q) begin
					wr_en = 1'b1; wr_addr = addr(s, h_q - HW'(2)); wr_data = tmp_q;
				end
				if (cmd_valid && free) begin
					cmd_take = 1'b1;
					state_d = BE_RD;
				end
			end
			BE_RD: begin
				// decide using latched height h_q
				if (free) begin
					if (cmd_q.nostack) begin
						emit = 1'b1; es = ST_NOSTACK; state_d = BE_IDLE;
					end else begin
						unique case (cmd_q.op)
							OP_SELECT, OP_NOP: begin
								emit = 1'b1; state_d = BE_IDLE;
							end
							OP_PUSH: begin
								emit = 1'b1;
								if (h_q >= HW'(STACK_DEPTH)) es = ST_FULL;
								else begin
									wr_en = 1'b1; wr_addr = addr(s, h_q);
									wr_data = to_val(cmd_q.value);
									h_we = 1'b1; h_set = h_q + 1'b1;
								end
								state_d = BE_IDLE;
							end
							OP_POP: begin
								if (h_q == '0) begin
									emit = 1'b1; es = ST_EMPTY; state_d = BE_IDLE;
								end else begin
									rd_en = 1'b1; rd_addr = addr(s, h_q - 1'b1);
									h_we = 1'b1; h_set = h_q - 1'b1;
									state_d = BE_OUT;
								end
							end
							OP_PEEK: begin
								if (h_q == '0) begin
									emit = 1'b1; es = ST_EMPTY; state_d = BE_IDLE;
								end else begin
									state_d = BE_PEEK;
								end
							end
							OP_SWAP: begin
								if (h_q < HW'(2)) begin
									emit = 1'b1; es = ST_EMPTY; state_d = BE_IDLE;
								end else begin
									rd_en = 1'b1; rd_addr = addr(s, h_q - 1'b1);
									state_d = BE_SWAP_RD2;
								end
							end
							OP_CLEAR: begin
								emit = 1'b1; h_we = 1'b1; h_set = '0; state_d = BE_IDLE;
							end
							default: begin
								if (tgt == s || h_q == '0) begin
									if (tgt != s) begin
										h_we = 1'b1; h_idx = tgt; h_set = '0;
									end
									emit = 1'b1; state_d = BE_IDLE;
								end else begin
									state_d = BE_COPY;
								end
							end
						endcase
					end
				end
			end
			BE_SWAP_RD2: begin
				rd_en = 1'b1; rd_addr = addr(s, h_q - HW'(2));
				state_d = BE_SWAP_WR;
			end
			BE_SWAP_WR: begin
				// rd_q holds lower entry, tmp_q the top
				if (free) begin
					wr_en = 1'b1; wr_addr = addr(s, h_q - 1'b1); wr_data = rd_q;
					emit = 1'b1;
					state_d = BE_IDLE;
				end
			end
			BE_OUT: begin
				if (free) begin
					emit = 1'b1; ev = to_out(rd_q); state_d = BE_IDLE;
				end
			end
			BE_PEEK: begin
				// issue read for entry i, emit previous one
				if (free) begin
					if (rdv_q) begin
						emit = 1'b1; ev = to_out(rd_q);
						el = (wi_q + 1'b1 == n_q);
					end
					if (rdv_q && wi_q + 1'b1 == n_q) state_d = BE_IDLE;
					else if (i_q < n_q) begin
						rd_en = 1'b1; rd_addr = addr(s, h_q - 1'b1 - i_q);
					end
				end
			end
			BE_COPY: begin
				if (rdv_q) begin
					wr_en = 1'b1; wr_addr = addr(tgt, wi_q); wr_data = rd_q;
				end
				if (i_q < h_q) begin
					rd_en = 1'b1; rd_addr = addr(s, i_q);
				end
				if (rdv_q && wi_q + 1'b1 == h_q) begin
					if (free) begin
						emit = 1'b1;
						h_we = 1'b1; h_idx = tgt; h_set = h_q;
						state_d = BE_IDLE;
					end else begin
						wr_en = 1'b0; rd_en = 1'b0;
					end
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
			h_q <= hs;
			n_q <= (cmd.count == '0 || 32'(cmd.count) > 32'(hs)) ? hs : HW'(cmd.count);
		end
		if (state_q == BE_SWAP_RD2) tmp_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
			i_q <= '0;
			wi_q <= '0;
			rdv_q <= 1'b0;
			ovld_q <= 1'b0;
			for (int k = 0; k < STACK_COUNT; k++) height_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (h_we) height_q[h_idx] <= h_set;
			if (state_q == BE_RD) begin
				i_q <= '0; wi_q <= '0; rdv_q <= 1'b0;
			end else if (state_q == BE_PEEK || state_q == BE_COPY) begin
				// copy holds its last entry until the result register is free
				if (state_q == BE_PEEK ? free : !(rdv_q && wi_q + 1'b1 == h_q && !free)) begin
					if (rdv_q) wi_q <= wi_q + 1'b1;
					rdv_q <= rd_en;
					if (rd_en) i_q <= i_q + 1'b1;
				end
			end
			if (emit) ovld_q <= 1'b1;
			else if (!out_stall) ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) swap_wr2_q <= 1'b0;
		else swap_wr2_q <= (state_q == BE_SWAP_WR) && free;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ov_q <= ev;
			os_q <= es;
			ol_q <= el;
		end
	end

	assign out_valid = ovld_q;
	assign read_value = ov_q;
	assign status = os_q;
	assign last_result = ol_q;

	`MSE_ASSERT(a_take_idle, clk, arst_n, !cmd_take || state_q == BE_IDLE, "take outside idle")
	`MSE_ASSERT(a_no_emit_stall, clk, arst_n, !(emit && ovld_q && out_stall), "result overwritten")
	`MSE_ASSERT_NEXT(a_take_rd, clk, arst_n, cmd_take, state_q == BE_RD, "take not followed by decode")
endmodule
